@@ hdl/ffha_pkg.sv @@
package ffha_pkg;

  localparam int HEAP_BYTES      = 65536;
  localparam int PAGE_BYTES      = 4096;
  localparam int HEADER_BYTES    = 8;
  localparam int MIN_CHUNK_BYTES = 16;

  localparam int ADDR_W   = $clog2(HEAP_BYTES);
  localparam int SIZE_W   = 17;
  localparam int HDR_W    = SIZE_W + 1;
  localparam int POS_W    = SIZE_W + 1;
  localparam int PAGE_LOG = $clog2(PAGE_BYTES);

  localparam logic [HDR_W-1:0] INIT_HDR = HDR_W'(PAGE_BYTES);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FAULT    = 2'd2
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [HDR_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } hdr_req_t;

  typedef struct packed {
    logic [15:0] block_offset;
    status_t     status;
  } res_t;

endpackage

@@ hdl/ffha_hdr_ram.sv @@
module ffha_hdr_ram (
  input  logic                               clk,
  input  ffha_pkg::hdr_req_t                 req,
  output logic [ffha_pkg::HDR_W-1:0]         rd_data
);
  import ffha_pkg::*;

  logic [HDR_W-1:0] mem [HEAP_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ hdl/ffha_ctrl.sv @@
module ffha_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [16:0]                   request_bytes,
  input  logic [15:0]                   free_offset,
  input  logic [ffha_pkg::SIZE_W-1:0]   limit,
  input  logic                          res_ready,
  output logic                          res_valid,
  output ffha_pkg::res_t                res,
  output ffha_pkg::hdr_req_t            hdr_req,
  input  logic [ffha_pkg::HDR_W-1:0]    hdr_rd_data
);
  import ffha_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_A_WALK  = 9'b000000100,
    S_A_GROW  = 9'b000001000,
    S_A_RD    = 9'b000010000,
    S_A_MARK  = 9'b000100000,
    S_F_HEAD  = 9'b001000000,
    S_F_MERGE = 9'b010000000,
    S_RESULT  = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [SIZE_W-1:0]   heap_top, heap_top_next;
  logic                halted, halted_next;
  logic [POS_W-1:0]    need, need_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [POS_W-1:0]    nxt, nxt_next;
  logic [SIZE_W-1:0]   acc, acc_next;
  res_t                res_q, res_next;

  logic [SIZE_W-1:0]   rd_size;
  logic                rd_used;
  logic [POS_W-1:0]    req_need, need_in;
  logic [SIZE_W-1:0]   free_pos;
  logic [POS_W-1:0]    walk_pos;
  logic [POS_W-1:0]    split_pos;
  logic [SIZE_W-1:0]   split_size;
  logic [POS_W-1:0]    grow, top_grown;
  logic [POS_W-1:0]    sum_raw, nxt_new;
  logic [SIZE_W-1:0]   sum_sat;

  assign rd_size    = hdr_rd_data[SIZE_W-1:0];
  assign rd_used    = hdr_rd_data[HDR_W-1];
  assign req_need   = {1'b0, request_bytes} + POS_W'(HEADER_BYTES);
  assign need_in    = (req_need < POS_W'(MIN_CHUNK_BYTES)) ? POS_W'(MIN_CHUNK_BYTES) : req_need;
  assign free_pos   = {1'b0, free_offset} - SIZE_W'(HEADER_BYTES);
  assign walk_pos   = pos + {1'b0, rd_size};
  assign split_pos  = pos + need;
  assign split_size = rd_size - need[SIZE_W-1:0];
  assign grow       = (POS_W'(need >> PAGE_LOG) + POS_W'(1)) << PAGE_LOG;
  assign top_grown  = {1'b0, heap_top} + grow;
  assign sum_raw    = {1'b0, acc} + {1'b0, rd_size};
  assign sum_sat    = sum_raw[POS_W-1] ? '1 : sum_raw[SIZE_W-1:0];
  assign nxt_new    = nxt + {1'b0, rd_size};

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res       = res_q;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    heap_top_next = heap_top;
    halted_next   = halted;
    need_next     = need;
    pos_next      = pos;
    nxt_next      = nxt;
    acc_next      = acc;
    res_next      = res_q;
    hdr_req       = '0;

    unique case (state)
      S_CLEAR: begin
        hdr_req.wr_en   = 1'b1;
        hdr_req.wr_addr = clr_addr;
        hdr_req.wr_data = (clr_addr == '0) ? INIT_HDR : '0;
        clr_addr_next   = clr_addr + ADDR_W'(1);
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          priority if (halted) begin
            res_next   = '{block_offset: '0, status: ST_FAULT};
            state_next = S_RESULT;
          end else if (cmd == CMD_ALLOC) begin
            need_next       = need_in;
            pos_next        = '0;
            hdr_req.rd_en   = 1'b1;
            hdr_req.rd_addr = '0;
            state_next      = S_A_WALK;
          end else if (free_offset < 16'(HEADER_BYTES) || free_pos >= heap_top) begin
            halted_next = 1'b1;
            res_next    = '{block_offset: '0, status: ST_FAULT};
            state_next  = S_RESULT;
          end else begin
            pos_next        = {1'b0, free_pos};
            hdr_req.rd_en   = 1'b1;
            hdr_req.rd_addr = free_pos[ADDR_W-1:0];
            state_next      = S_F_HEAD;
          end
        end
      end

      S_A_WALK: begin
        priority if (!rd_used && {1'b0, rd_size} >= need) begin
          if (rd_size != need[SIZE_W-1:0] && split_pos < POS_W'(HEAP_BYTES)) begin
            hdr_req.wr_en   = 1'b1;
            hdr_req.wr_addr = split_pos[ADDR_W-1:0];
            hdr_req.wr_data = {1'b0, split_size};
          end
          state_next = S_A_MARK;
        end else if (rd_size == '0) begin
          halted_next = 1'b1;
          res_next    = '{block_offset: '0, status: ST_FAULT};
          state_next  = S_RESULT;
        end else if (walk_pos == {1'b0, heap_top}) begin
          pos_next   = walk_pos;
          state_next = S_A_GROW;
        end else if (walk_pos > {1'b0, heap_top}) begin
          halted_next = 1'b1;
          res_next    = '{block_offset: '0, status: ST_FAULT};
          state_next  = S_RESULT;
        end else begin
          pos_next        = walk_pos;
          hdr_req.rd_en   = 1'b1;
          hdr_req.rd_addr = walk_pos[ADDR_W-1:0];
        end
      end

      S_A_GROW: begin
        if (top_grown > {1'b0, limit}) begin
          res_next   = '{block_offset: '0, status: ST_NO_SPACE};
          state_next = S_RESULT;
        end else begin
          if (heap_top < SIZE_W'(HEAP_BYTES)) begin
            hdr_req.wr_en   = 1'b1;
            hdr_req.wr_addr = heap_top[ADDR_W-1:0];
            hdr_req.wr_data = {1'b0, grow[SIZE_W-1:0]};
          end
          heap_top_next = top_grown[SIZE_W-1:0];
          state_next    = S_A_RD;
        end
      end

      S_A_RD: begin
        hdr_req.rd_en   = 1'b1;
        hdr_req.rd_addr = pos[ADDR_W-1:0];
        state_next      = S_A_WALK;
      end

      S_A_MARK: begin
        hdr_req.wr_en   = 1'b1;
        hdr_req.wr_addr = pos[ADDR_W-1:0];
        hdr_req.wr_data = {1'b1, need[SIZE_W-1:0]};
        res_next        = '{block_offset: pos[15:0] + 16'(HEADER_BYTES), status: ST_DONE};
        state_next      = S_RESULT;
      end

      S_F_HEAD: begin
        if (rd_size == '0) begin
          halted_next = 1'b1;
          res_next    = '{block_offset: '0, status: ST_FAULT};
          state_next  = S_RESULT;
        end else begin
          hdr_req.wr_en   = 1'b1;
          hdr_req.wr_addr = pos[ADDR_W-1:0];
          hdr_req.wr_data = {1'b0, rd_size};
          acc_next        = rd_size;
          nxt_next        = walk_pos;
          if (walk_pos >= {1'b0, heap_top}) begin
            res_next   = '{block_offset: '0, status: ST_DONE};
            state_next = S_RESULT;
          end else begin
            hdr_req.rd_en   = 1'b1;
            hdr_req.rd_addr = walk_pos[ADDR_W-1:0];
            state_next      = S_F_MERGE;
          end
        end
      end

      S_F_MERGE: begin
        priority if (rd_used) begin
          res_next   = '{block_offset: '0, status: ST_DONE};
          state_next = S_RESULT;
        end else if (rd_size == '0) begin
          halted_next = 1'b1;
          res_next    = '{block_offset: '0, status: ST_FAULT};
          state_next  = S_RESULT;
        end else begin
          hdr_req.wr_en   = 1'b1;
          hdr_req.wr_addr = pos[ADDR_W-1:0];
          hdr_req.wr_data = {1'b0, sum_sat};
          acc_next        = sum_sat;
          nxt_next        = nxt_new;
          if (nxt_new >= {1'b0, heap_top}) begin
            res_next   = '{block_offset: '0, status: ST_DONE};
            state_next = S_RESULT;
          end else begin
            hdr_req.rd_en   = 1'b1;
            hdr_req.rd_addr = nxt_new[ADDR_W-1:0];
          end
        end
      end

      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      heap_top <= SIZE_W'(PAGE_BYTES);
      halted   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      heap_top <= heap_top_next;
      halted   <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    need  <= need_next;
    pos   <= pos_next;
    nxt   <= nxt_next;
    acc   <= acc_next;
    res_q <= res_next;
  end

`ifndef SYNTHESIS
  a_top_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> heap_top >= $past(heap_top))
    else $error("heap top moved down");

  a_top_bounded: assert property (@(posedge clk) disable iff (rst)
    heap_top <= SIZE_W'(HEAP_BYTES) && heap_top[PAGE_LOG-1:0] == '0)
    else $error("heap top beyond store or not page aligned");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && halted) |-> res_q.status == ST_FAULT)
    else $error("halted block gave a non-fault status");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hdr_req.wr_en)
    else $error("header write while idle");
`endif

endmodule

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator over an implicit list of chunk headers.
// Input channel (in_valid / in_stall): cmd selects allocate (request_bytes)
// or free (free_offset). A transaction is taken only while the walker is
// idle; one result transaction follows each input transaction.
// Output channel (out_valid / out_stall): block_offset and status sit in an
// output register, so a stalled result does not block the next input
// transaction; the walker waits only if a second result is ready first.
// Config channel (cfg_valid / cfg_ready): heap_limit_bytes, always ready.
// Sequence: allocate reads headers from offset 0 (S_A_WALK), one header read
// per chunk walked, and on reaching the heap top grows it (S_A_GROW, S_A_RD);
// a fitting chunk is split if larger and marked used (S_A_MARK). Free reads the
// freed header (S_F_HEAD), then merges each following free chunk (S_F_MERGE),
// one header read each, until a used chunk or the heap top. The next input is
// taken in the cycle after the result leaves the walker. The header RAM has a
// registered read and separate write and read ports.
// Reset: a clearing pass writes all 65536 header entries, one per cycle,
// leaving one free page at offset 0; in_stall stays high until it ends.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [16:0] request_bytes,
  input  logic [15:0] free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] block_offset,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] heap_limit_bytes
);
  import ffha_pkg::*;

  logic [SIZE_W-1:0] limit_reg;
  logic [SIZE_W-1:0] limit_eff;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  hdr_req_t          hdr_req;
  logic [HDR_W-1:0]  hdr_rd_data;

  assign cfg_ready = 1'b1;
  assign limit_eff = (limit_reg > SIZE_W'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES) : limit_reg;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= SIZE_W'(HEAP_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      limit_reg <= heap_limit_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      block_offset <= res.block_offset;
      status       <= res.status;
    end
  end

  ffha_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .request_bytes(request_bytes),
    .free_offset  (free_offset),
    .limit        (limit_eff),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res),
    .hdr_req      (hdr_req),
    .hdr_rd_data  (hdr_rd_data)
  );

  ffha_hdr_ram u_hdr_ram (
    .clk    (clk),
    .req    (hdr_req),
    .rd_data(hdr_rd_data)
  );

endmodule
